// ===== design/dec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_pkg
// Shared widths and types of the disc collision pipeline: geometry bundle,
// sideband that travels with every item, and the divider chain stage word.
// ----------------------------------------------------------------------------
package dec_pkg;

  localparam int unsigned VEL_W   = 32;
  localparam int unsigned DIFF_W  = 33;   // difference of two Q16.16 values
  localparam int unsigned SQ_W    = 66;   // squares, dot product magnitude
  localparam int unsigned MSUM_W  = 32;
  localparam int unsigned MASS_W  = 31;
  localparam int unsigned CHUNK_W = 33;   // operand slice for one multiplier
  localparam int unsigned DEN_W   = 98;   // msum * |d|^2
  localparam int unsigned NUM_W   = 130;  // 2 * m * |dot| * |d component|
  localparam int unsigned Q_W     = 35;   // quotient bits, top bit marks clamp
  localparam int unsigned CMP_W   = NUM_W + 2;
  localparam int unsigned NLANE   = 4;    // a.x, a.y, b.x, b.y corrections
  localparam int unsigned NCHUNK  = 3;
  localparam int unsigned TOP_BIT = Q_W - 1;

  typedef struct packed {
    logic                        hit;
    logic                        degen;
    logic                        dotneg;
    logic                        dxneg;
    logic                        dyneg;
    logic [NLANE-1:0][VEL_W-1:0] vel;   // a.x, a.y, b.x, b.y
  } sideband_t;

  typedef struct packed {
    sideband_t           sb;
    logic [SQ_W-1:0]     d2;
    logic [SQ_W-1:0]     dotmag;
    logic [DIFF_W-1:0]   dxmag;
    logic [DIFF_W-1:0]   dymag;
    logic [MSUM_W-1:0]   msum;
    logic [MASS_W-1:0]   am;
    logic [MASS_W-1:0]   bm;
  } geo_t;

  typedef struct packed {
    sideband_t                   sb;
    logic [DEN_W-1:0]            den;
    logic [NLANE-1:0][NUM_W-1:0] rem;
    logic [NLANE-1:0][Q_W-1:0]   q;
  } div_t;

endpackage
`default_nettype wire

// ===== design/dec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_front
// Three stages of geometry: differences, squares and products, then the
// overlap test, the degenerate test and the dot product magnitude.
// ----------------------------------------------------------------------------
module dec_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_take,
  input  wire logic signed [31:0]  a_pos_x,
  input  wire logic signed [31:0]  a_pos_y,
  input  wire logic signed [31:0]  a_vel_x,
  input  wire logic signed [31:0]  a_vel_y,
  input  wire logic [30:0]         a_radius,
  input  wire logic [30:0]         a_mass,
  input  wire logic signed [31:0]  b_pos_x,
  input  wire logic signed [31:0]  b_pos_y,
  input  wire logic signed [31:0]  b_vel_x,
  input  wire logic signed [31:0]  b_vel_y,
  input  wire logic [30:0]         b_radius,
  input  wire logic [30:0]         b_mass,
  output logic                     geo_valid,
  output dec_pkg::geo_t            geo
);

  // Stage 1
  logic                                   v1_r;
  logic signed [dec_pkg::DIFF_W-1:0]      s1_dx_r, s1_dy_r, s1_dvx_r, s1_dvy_r;
  logic [dec_pkg::MSUM_W-1:0]             s1_rs_r, s1_msum_r;
  logic [dec_pkg::MASS_W-1:0]             s1_am_r, s1_bm_r;
  logic [dec_pkg::NLANE-1:0][dec_pkg::VEL_W-1:0] s1_vel_r;

  // Stage 2
  logic                                   v2_r;
  logic signed [dec_pkg::SQ_W-1:0]        s2_dx2_r, s2_dy2_r, s2_pdx_r, s2_pdy_r;
  logic [63:0]                            s2_rs2_r;
  logic [dec_pkg::DIFF_W-1:0]             s2_dxmag_r, s2_dymag_r;
  logic                                   s2_dxneg_r, s2_dyneg_r;
  logic [dec_pkg::MSUM_W-1:0]             s2_msum_r;
  logic [dec_pkg::MASS_W-1:0]             s2_am_r, s2_bm_r;
  logic [dec_pkg::NLANE-1:0][dec_pkg::VEL_W-1:0] s2_vel_r;

  logic [dec_pkg::DIFF_W-1:0]             dx_neg, dy_neg;

  // Stage 3
  logic                                   v3_r;
  dec_pkg::geo_t                          geo_r, geo_nxt;
  logic [dec_pkg::SQ_W:0]                 dot, dot_neg;
  logic [dec_pkg::SQ_W-1:0]               d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r   <= {a_pos_x[31], a_pos_x} - {b_pos_x[31], b_pos_x};
    s1_dy_r   <= {a_pos_y[31], a_pos_y} - {b_pos_y[31], b_pos_y};
    s1_dvx_r  <= {a_vel_x[31], a_vel_x} - {b_vel_x[31], b_vel_x};
    s1_dvy_r  <= {a_vel_y[31], a_vel_y} - {b_vel_y[31], b_vel_y};
    s1_rs_r   <= {1'b0, a_radius} + {1'b0, b_radius};
    s1_msum_r <= {1'b0, a_mass} + {1'b0, b_mass};
    s1_am_r   <= a_mass;
    s1_bm_r   <= b_mass;
    s1_vel_r  <= {b_vel_y, b_vel_x, a_vel_y, a_vel_x};
  end

  assign dx_neg = -s1_dx_r;
  assign dy_neg = -s1_dy_r;

  always_ff @(posedge clk) begin
    s2_dx2_r   <= s1_dx_r * s1_dx_r;
    s2_dy2_r   <= s1_dy_r * s1_dy_r;
    s2_pdx_r   <= s1_dvx_r * s1_dx_r;
    s2_pdy_r   <= s1_dvy_r * s1_dy_r;
    s2_rs2_r   <= s1_rs_r * s1_rs_r;
    s2_dxmag_r <= s1_dx_r[dec_pkg::DIFF_W-1] ? dx_neg : s1_dx_r;
    s2_dymag_r <= s1_dy_r[dec_pkg::DIFF_W-1] ? dy_neg : s1_dy_r;
    s2_dxneg_r <= s1_dx_r[dec_pkg::DIFF_W-1];
    s2_dyneg_r <= s1_dy_r[dec_pkg::DIFF_W-1];
    s2_msum_r  <= s1_msum_r;
    s2_am_r    <= s1_am_r;
    s2_bm_r    <= s1_bm_r;
    s2_vel_r   <= s1_vel_r;
  end

  always_comb begin
    d2      = s2_dx2_r + s2_dy2_r;
    dot     = {s2_pdx_r[dec_pkg::SQ_W-1], s2_pdx_r} + {s2_pdy_r[dec_pkg::SQ_W-1], s2_pdy_r};
    dot_neg = -dot;
    geo_nxt.sb.hit    = d2 <= {2'b00, s2_rs2_r};
    geo_nxt.sb.degen  = geo_nxt.sb.hit && ((d2 == '0) || (s2_msum_r == '0));
    geo_nxt.sb.dotneg = dot[dec_pkg::SQ_W];
    geo_nxt.sb.dxneg  = s2_dxneg_r;
    geo_nxt.sb.dyneg  = s2_dyneg_r;
    geo_nxt.sb.vel    = s2_vel_r;
    geo_nxt.d2        = d2;
    geo_nxt.dotmag    = dot[dec_pkg::SQ_W] ? dot_neg[dec_pkg::SQ_W-1:0]
                                           : dot[dec_pkg::SQ_W-1:0];
    geo_nxt.dxmag     = s2_dxmag_r;
    geo_nxt.dymag     = s2_dymag_r;
    geo_nxt.msum      = s2_msum_r;
    geo_nxt.am        = s2_am_r;
    geo_nxt.bm        = s2_bm_r;
  end

  always_ff @(posedge clk) begin
    geo_r <= geo_nxt;
  end

  assign geo_valid = v3_r;
  assign geo       = geo_r;

endmodule
`default_nettype wire

// ===== design/dec_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_scale
// Four stages that build the shared denominator msum * |d|^2 and the four
// numerators 2 * m * |dot| * |d component| from sliced products.
// ----------------------------------------------------------------------------
module dec_scale (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           geo_valid,
  input  wire dec_pkg::geo_t  geo,
  output logic                div_valid,
  output dec_pkg::div_t       div
);

  localparam int unsigned PP_W = 2 * dec_pkg::CHUNK_W;

  // Stage 4: mass times dot slices, msum times |d|^2 slices.
  logic                        v4_r;
  logic [64:0]                 s4_pa_lo_r, s4_pa_hi_r, s4_pb_lo_r, s4_pb_hi_r;
  logic [64:0]                 s4_dn_lo_r, s4_dn_hi_r;
  logic [dec_pkg::DIFF_W-1:0]  s4_dxmag_r, s4_dymag_r;
  dec_pkg::sideband_t          s4_sb_r;
  logic [31:0]                 m2a, m2b;

  // Stage 5: assembled mass*dot terms and denominator.
  logic                        v5_r;
  logic [dec_pkg::DEN_W-1:0]   s5_ma_r, s5_mb_r, s5_den_r;
  logic [dec_pkg::DIFF_W-1:0]  s5_dxmag_r, s5_dymag_r;
  dec_pkg::sideband_t          s5_sb_r;

  // Stage 6: slice products of the numerators.
  logic                        v6_r;
  logic [dec_pkg::NLANE-1:0][dec_pkg::NCHUNK-1:0][PP_W-1:0] s6_pp_r;
  logic [dec_pkg::DEN_W-1:0]   s6_den_r;
  dec_pkg::sideband_t          s6_sb_r;
  logic [dec_pkg::NCHUNK*dec_pkg::CHUNK_W-1:0] mfac [dec_pkg::NLANE];
  logic [dec_pkg::DIFF_W-1:0]  cfac [dec_pkg::NLANE];

  // Stage 7: numerators, first divider word.
  logic                        v7_r;
  dec_pkg::div_t               div_r, div_nxt;
  logic [dec_pkg::NUM_W+1:0]   nsum [dec_pkg::NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= geo_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  assign m2a = {geo.am, 1'b0};
  assign m2b = {geo.bm, 1'b0};

  always_ff @(posedge clk) begin
    s4_pa_lo_r <= m2b * geo.dotmag[dec_pkg::CHUNK_W-1:0];
    s4_pa_hi_r <= m2b * geo.dotmag[dec_pkg::SQ_W-1:dec_pkg::CHUNK_W];
    s4_pb_lo_r <= m2a * geo.dotmag[dec_pkg::CHUNK_W-1:0];
    s4_pb_hi_r <= m2a * geo.dotmag[dec_pkg::SQ_W-1:dec_pkg::CHUNK_W];
    s4_dn_lo_r <= geo.msum * geo.d2[dec_pkg::CHUNK_W-1:0];
    s4_dn_hi_r <= geo.msum * geo.d2[dec_pkg::SQ_W-1:dec_pkg::CHUNK_W];
    s4_dxmag_r <= geo.dxmag;
    s4_dymag_r <= geo.dymag;
    s4_sb_r    <= geo.sb;
  end

  always_ff @(posedge clk) begin
    s5_ma_r    <= {s4_pa_hi_r, 33'd0} + {33'd0, s4_pa_lo_r};
    s5_mb_r    <= {s4_pb_hi_r, 33'd0} + {33'd0, s4_pb_lo_r};
    s5_den_r   <= {s4_dn_hi_r, 33'd0} + {33'd0, s4_dn_lo_r};
    s5_dxmag_r <= s4_dxmag_r;
    s5_dymag_r <= s4_dymag_r;
    s5_sb_r    <= s4_sb_r;
  end

  // Lanes 0 and 1 correct disc a and scale by the mass of b; lanes 2 and 3 the reverse.
  always_comb begin
    mfac[0] = {1'b0, s5_ma_r};
    mfac[1] = {1'b0, s5_ma_r};
    mfac[2] = {1'b0, s5_mb_r};
    mfac[3] = {1'b0, s5_mb_r};
    cfac[0] = s5_dxmag_r;
    cfac[1] = s5_dymag_r;
    cfac[2] = s5_dxmag_r;
    cfac[3] = s5_dymag_r;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < dec_pkg::NLANE; l++) begin
      for (int j = 0; j < dec_pkg::NCHUNK; j++) begin
        s6_pp_r[l][j] <= mfac[l][j*dec_pkg::CHUNK_W +: dec_pkg::CHUNK_W] * cfac[l];
      end
    end
    s6_den_r <= s5_den_r;
    s6_sb_r  <= s5_sb_r;
  end

  always_comb begin
    div_nxt.sb  = s6_sb_r;
    div_nxt.den = s6_den_r;
    for (int l = 0; l < dec_pkg::NLANE; l++) begin
      nsum[l] = {s6_pp_r[l][2], 66'd0} + {33'd0, s6_pp_r[l][1], 33'd0}
              + {66'd0, s6_pp_r[l][0]};
      div_nxt.rem[l] = nsum[l][dec_pkg::NUM_W-1:0];
      div_nxt.q[l]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign div_valid = v7_r;
  assign div       = div_r;

endmodule
`default_nettype wire

// ===== design/dec_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_div_cell
// One restoring division step for all four lanes at quotient bit BIT_POS.
// The cell compares each remainder with the shared denominator shifted to
// that bit and hands the updated word to the next cell.
// ----------------------------------------------------------------------------
module dec_div_cell #(
  parameter int unsigned BIT_POS = dec_pkg::TOP_BIT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           prev_valid,
  input  wire dec_pkg::div_t  prev,
  output logic                next_valid,
  output dec_pkg::div_t       next
);

  logic                        valid_r;
  dec_pkg::div_t               word_r, word_nxt;
  logic [dec_pkg::CMP_W-1:0]   dsh;
  logic [dec_pkg::CMP_W-1:0]   rem_ext [dec_pkg::NLANE];
  logic [dec_pkg::CMP_W-1:0]   diff [dec_pkg::NLANE];

  assign dsh = {{(dec_pkg::CMP_W - dec_pkg::DEN_W){1'b0}}, prev.den} << BIT_POS;

  always_comb begin
    word_nxt = prev;
    for (int l = 0; l < dec_pkg::NLANE; l++) begin
      rem_ext[l] = {2'b00, prev.rem[l]};
      diff[l]    = rem_ext[l] - dsh;
      if (rem_ext[l] >= dsh) begin
        word_nxt.rem[l]          = diff[l][dec_pkg::NUM_W-1:0];
        word_nxt.q[l][BIT_POS]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign next_valid = valid_r;
  assign next       = word_r;

endmodule
`default_nettype wire

// ===== design/disc_elastic_collision.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one disc pair per cycle; busy stays low, the pipeline never stalls.
// The depth is set by 7 arithmetic stages, a chain of 35 division cells (one
// quotient bit each) and the output register. Reset clears only the valid bits.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// disc_elastic_collision
// Elastic collision of two discs in Q16.16: overlap test, exact velocity
// corrections by a pipelined divider chain, saturation to 32 bits.
// ----------------------------------------------------------------------------
module disc_elastic_collision (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_a_pos_x,
  input  wire logic signed [31:0] in_a_pos_y,
  input  wire logic signed [31:0] in_a_vel_x,
  input  wire logic signed [31:0] in_a_vel_y,
  input  wire logic [30:0]        in_a_radius,
  input  wire logic [30:0]        in_a_mass,
  input  wire logic signed [31:0] in_b_pos_x,
  input  wire logic signed [31:0] in_b_pos_y,
  input  wire logic signed [31:0] in_b_vel_x,
  input  wire logic signed [31:0] in_b_vel_y,
  input  wire logic [30:0]        in_b_radius,
  input  wire logic [30:0]        in_b_mass,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic                    out_degenerate,
  output logic signed [31:0]      out_a_new_vel_x,
  output logic signed [31:0]      out_a_new_vel_y,
  output logic signed [31:0]      out_b_new_vel_x,
  output logic signed [31:0]      out_b_new_vel_y
);

  localparam int unsigned NSTEP = dec_pkg::Q_W;

  logic                 geo_valid;
  dec_pkg::geo_t        geo;
  logic                 chain_valid [NSTEP+1];
  dec_pkg::div_t        chain [NSTEP+1];
  dec_pkg::div_t        last;

  logic                 strobe_r;
  logic                 hit_r, degen_r;
  logic [dec_pkg::NLANE-1:0][dec_pkg::VEL_W-1:0] vel_r, vel_nxt;

  logic [dec_pkg::Q_W-1:0] corr [dec_pkg::NLANE];
  logic signed [36:0]      corr_s [dec_pkg::NLANE];
  logic signed [36:0]      vext [dec_pkg::NLANE];
  logic signed [36:0]      sum [dec_pkg::NLANE];
  logic                    cneg [dec_pkg::NLANE];

  assign busy = 1'b0;

  dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (start && !busy),
    .a_pos_x   (in_a_pos_x),
    .a_pos_y   (in_a_pos_y),
    .a_vel_x   (in_a_vel_x),
    .a_vel_y   (in_a_vel_y),
    .a_radius  (in_a_radius),
    .a_mass    (in_a_mass),
    .b_pos_x   (in_b_pos_x),
    .b_pos_y   (in_b_pos_y),
    .b_vel_x   (in_b_vel_x),
    .b_vel_y   (in_b_vel_y),
    .b_radius  (in_b_radius),
    .b_mass    (in_b_mass),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  dec_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .geo_valid (geo_valid),
    .geo       (geo),
    .div_valid (chain_valid[0]),
    .div       (chain[0])
  );

  // The first cell decides the clamp bit, the rest produce bits 33 down to 0.
  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    dec_div_cell #(
      .BIT_POS (dec_pkg::TOP_BIT - i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .prev_valid (chain_valid[i]),
      .prev       (chain[i]),
      .next_valid (chain_valid[i+1]),
      .next       (chain[i+1])
    );
  end

  assign last = chain[NSTEP];

  always_comb begin
    cneg[0] = last.sb.dxneg;
    cneg[1] = last.sb.dyneg;
    cneg[2] = last.sb.dxneg;
    cneg[3] = last.sb.dyneg;
    for (int l = 0; l < dec_pkg::NLANE; l++) begin
      corr[l]   = last.q[l][dec_pkg::TOP_BIT]
                ? {1'b1, {(dec_pkg::Q_W-1){1'b0}}}
                : {1'b0, last.q[l][dec_pkg::Q_W-2:0]};
      corr_s[l] = (last.sb.dotneg ^ cneg[l]) ? -$signed({2'b00, corr[l]})
                                             : $signed({2'b00, corr[l]});
      vext[l]   = $signed({{5{last.sb.vel[l][31]}}, last.sb.vel[l]});
      // Disc a moves against the correction, disc b with it.
      sum[l]    = (l < 2) ? (vext[l] - corr_s[l]) : (vext[l] + corr_s[l]);
      if (!last.sb.hit || last.sb.degen) begin
        vel_nxt[l] = last.sb.vel[l];
      end else if (sum[l][36:31] != {6{sum[l][36]}}) begin
        vel_nxt[l] = sum[l][36] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        vel_nxt[l] = sum[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= chain_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= last.sb.hit;
    degen_r <= last.sb.degen;
    vel_r   <= vel_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_hit         = hit_r;
  assign out_degenerate  = degen_r;
  assign out_a_new_vel_x = vel_r[0];
  assign out_a_new_vel_y = vel_r[1];
  assign out_b_new_vel_x = vel_r[2];
  assign out_b_new_vel_y = vel_r[3];

endmodule
`default_nettype wire
